// File: rtl/nfcs_pkg.sv
// shared types, codes and the bus cycle table of the nor flash command sequencer
`default_nettype none

package nfcs_pkg;

    // host byte address width that is decoded (upper bits are ignored)
    localparam int ADDR_BITS = 24;

    localparam int BYTE_ADDR_W = 24;
    localparam int OFF_W       = 23;
    localparam int DATA_W      = 16;
    localparam int ACTION_W    = 3;
    localparam int KIND_W      = 3;
    localparam int STEP_W      = 3;

    localparam logic [BYTE_ADDR_W-1:0] ADDR_MASK = (ADDR_BITS >= BYTE_ADDR_W) ?
        {BYTE_ADDR_W{1'b1}} : BYTE_ADDR_W'((33'd1 << ADDR_BITS) - 33'd1);

    // request codes
    localparam logic [ACTION_W-1:0] ACT_PROGRAM  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_ERASE    = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_ID       = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_CFI      = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_RESET    = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_READ     = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_READ_RET = 3'd6;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_WRITE  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_READ   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DONE   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RDATA  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_REJECT = 3'd4;

    // poll phases
    localparam logic [1:0] PHASE_IDLE  = 2'd0;
    localparam logic [1:0] PHASE_FIRST = 2'd1;
    localparam logic [1:0] PHASE_LATER = 2'd2;

    // flash command words and addresses
    localparam logic [OFF_W-1:0]  UNLOCK1_ADDR = 23'h555;
    localparam logic [OFF_W-1:0]  UNLOCK2_ADDR = 23'h2AA;
    localparam logic [OFF_W-1:0]  CFI_ADDR     = 23'h55;
    localparam logic [DATA_W-1:0] UNLOCK1_DATA = 16'hAA;
    localparam logic [DATA_W-1:0] UNLOCK2_DATA = 16'h55;
    localparam logic [DATA_W-1:0] CMD_PROGRAM  = 16'hA0;
    localparam logic [DATA_W-1:0] CMD_ERASE    = 16'h80;
    localparam logic [DATA_W-1:0] CMD_SECTOR   = 16'h30;
    localparam logic [DATA_W-1:0] CMD_ID       = 16'h90;
    localparam logic [DATA_W-1:0] CMD_CFI      = 16'h98;
    localparam logic [DATA_W-1:0] CMD_RESET    = 16'hF0;
    localparam int TOGGLE_BIT = 6;

    // sequences the emitter walks through
    typedef logic [3:0] seq_t;
    localparam seq_t SEQ_PROGRAM  = 4'd0;
    localparam seq_t SEQ_ERASE    = 4'd1;
    localparam seq_t SEQ_ID       = 4'd2;
    localparam seq_t SEQ_CFI      = 4'd3;
    localparam seq_t SEQ_RESET    = 4'd4;
    localparam seq_t SEQ_READ     = 4'd5;
    localparam seq_t SEQ_RDATA    = 4'd6;
    localparam seq_t SEQ_REJECT   = 4'd7;
    localparam seq_t SEQ_DONE     = 4'd8;
    localparam seq_t SEQ_POLLREAD = 4'd9;

    typedef struct packed {
        logic              valid;
        seq_t              seq;
        logic [OFF_W-1:0]  off;
        logic [DATA_W-1:0] dat;
    } job_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [OFF_W-1:0]  word_offset;
        logic [DATA_W-1:0] bus_data;
        logic              last;
    } result_t;

    function automatic result_t mk(input logic [KIND_W-1:0] kind,
                                   input logic [OFF_W-1:0] off,
                                   input logic [DATA_W-1:0] dat,
                                   input logic last);
        result_t r;
        r.kind        = kind;
        r.word_offset = off;
        r.bus_data    = dat;
        r.last        = last;
        return r;
    endfunction

    // unlock pair at steps 0 and 1, and in an erase again at steps 3 and 4
    function automatic result_t unlock_step(input logic second);
        result_t r;
        if (second) begin
            r = mk(KIND_WRITE, UNLOCK2_ADDR, UNLOCK2_DATA, 1'b0);
        end else begin
            r = mk(KIND_WRITE, UNLOCK1_ADDR, UNLOCK1_DATA, 1'b0);
        end
        return r;
    endfunction

    // one bus cycle or report of a sequence
    function automatic result_t step_result(input seq_t seq,
                                            input logic [STEP_W-1:0] idx,
                                            input logic [OFF_W-1:0] off,
                                            input logic [DATA_W-1:0] dat);
        result_t r;
        r = mk(KIND_REJECT, '0, '0, 1'b1);
        unique case (seq)
            SEQ_PROGRAM: begin
                unique case (idx)
                    3'd0, 3'd1: r = unlock_step(idx[0]);
                    3'd2:       r = mk(KIND_WRITE, UNLOCK1_ADDR, CMD_PROGRAM, 1'b0);
                    3'd3:       r = mk(KIND_WRITE, off, dat, 1'b0);
                    3'd4:       r = mk(KIND_READ, off, '0, 1'b0);
                    default:    r = mk(KIND_READ, off, '0, 1'b1);
                endcase
            end
            SEQ_ERASE: begin
                unique case (idx)
                    3'd0, 3'd1: r = unlock_step(idx[0]);
                    3'd2:       r = mk(KIND_WRITE, UNLOCK1_ADDR, CMD_ERASE, 1'b0);
                    3'd3, 3'd4: r = unlock_step(~idx[0]);
                    3'd5:       r = mk(KIND_WRITE, off, CMD_SECTOR, 1'b0);
                    3'd6:       r = mk(KIND_READ, off, '0, 1'b0);
                    default:    r = mk(KIND_READ, off, '0, 1'b1);
                endcase
            end
            SEQ_ID: begin
                unique case (idx)
                    3'd0, 3'd1: r = unlock_step(idx[0]);
                    default:    r = mk(KIND_WRITE, UNLOCK1_ADDR, CMD_ID, 1'b1);
                endcase
            end
            SEQ_CFI:      r = mk(KIND_WRITE, CFI_ADDR, CMD_CFI, 1'b1);
            SEQ_RESET:    r = mk(KIND_WRITE, '0, CMD_RESET, 1'b1);
            SEQ_READ:     r = mk(KIND_READ, off, '0, 1'b1);
            SEQ_RDATA:    r = mk(KIND_RDATA, '0, dat, 1'b1);
            SEQ_DONE:     r = mk(KIND_DONE, off, dat, 1'b1);
            SEQ_POLLREAD: r = mk(KIND_READ, off, '0, 1'b1);
            default:      r = mk(KIND_REJECT, '0, '0, 1'b1);
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/nfcs_ctrl.sv
// request decode and toggle poll state of the nor flash command sequencer
`default_nettype none

module nfcs_ctrl (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              accept,
    input  wire logic [nfcs_pkg::ACTION_W-1:0]     action,
    input  wire logic [nfcs_pkg::BYTE_ADDR_W-1:0]  byte_address,
    input  wire logic [nfcs_pkg::DATA_W-1:0]       write_data,
    input  wire logic [nfcs_pkg::DATA_W-1:0]       read_data,
    output nfcs_pkg::job_t                         job
);

    logic [1:0]                   phase_reg, phase_next;
    logic                         prev_bit_reg, prev_bit_next;
    logic [nfcs_pkg::OFF_W-1:0]   poll_off_reg, poll_off_next;
    logic [nfcs_pkg::BYTE_ADDR_W-1:0] masked;
    logic [nfcs_pkg::OFF_W-1:0]   off;
    logic                         bit6;

    assign masked = byte_address & nfcs_pkg::ADDR_MASK;
    assign off    = masked[nfcs_pkg::BYTE_ADDR_W-1:1];
    assign bit6   = read_data[nfcs_pkg::TOGGLE_BIT];

    always_comb begin
        phase_next    = phase_reg;
        prev_bit_next = prev_bit_reg;
        poll_off_next = poll_off_reg;
        job.valid     = 1'b1;
        job.seq       = nfcs_pkg::SEQ_REJECT;
        job.off       = off;
        job.dat       = write_data;
        if (phase_reg != nfcs_pkg::PHASE_IDLE) begin
            if (action != nfcs_pkg::ACT_READ_RET) begin
                job.seq = nfcs_pkg::SEQ_REJECT;
            end else if (phase_reg == nfcs_pkg::PHASE_FIRST) begin
                // first status word only seeds the compare
                job.valid     = 1'b0;
                prev_bit_next = bit6;
                phase_next    = nfcs_pkg::PHASE_LATER;
            end else if (bit6 == prev_bit_reg) begin
                job.seq    = nfcs_pkg::SEQ_DONE;
                job.off    = poll_off_reg;
                job.dat    = read_data;
                phase_next = nfcs_pkg::PHASE_IDLE;
            end else begin
                job.seq       = nfcs_pkg::SEQ_POLLREAD;
                job.off       = poll_off_reg;
                prev_bit_next = bit6;
            end
        end else begin
            unique case (action)
                nfcs_pkg::ACT_PROGRAM: begin
                    job.seq       = nfcs_pkg::SEQ_PROGRAM;
                    poll_off_next = off;
                    phase_next    = nfcs_pkg::PHASE_FIRST;
                end
                nfcs_pkg::ACT_ERASE: begin
                    job.seq       = nfcs_pkg::SEQ_ERASE;
                    poll_off_next = off;
                    phase_next    = nfcs_pkg::PHASE_FIRST;
                end
                nfcs_pkg::ACT_ID:    job.seq = nfcs_pkg::SEQ_ID;
                nfcs_pkg::ACT_CFI:   job.seq = nfcs_pkg::SEQ_CFI;
                nfcs_pkg::ACT_RESET: job.seq = nfcs_pkg::SEQ_RESET;
                nfcs_pkg::ACT_READ:  job.seq = nfcs_pkg::SEQ_READ;
                nfcs_pkg::ACT_READ_RET: begin
                    job.seq = nfcs_pkg::SEQ_RDATA;
                    job.dat = read_data;
                end
                default: job.seq = nfcs_pkg::SEQ_REJECT;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= nfcs_pkg::PHASE_IDLE;
            prev_bit_reg <= 1'b0;
            poll_off_reg <= '0;
        end else if (accept) begin
            phase_reg    <= phase_next;
            prev_bit_reg <= prev_bit_next;
            poll_off_reg <= poll_off_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/nfcs_emit.sv
// job register, step counter and output register of the nor flash command sequencer
`default_nettype none

module nfcs_emit (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            accept,
    input  wire nfcs_pkg::job_t  job_in,
    output logic                 ready,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output nfcs_pkg::result_t    out_result
);

    nfcs_pkg::job_t               job_reg;
    logic [nfcs_pkg::STEP_W-1:0]  step_reg;
    logic                         out_valid_reg;
    nfcs_pkg::result_t            out_reg;
    nfcs_pkg::result_t            cur;
    logic                         emit;
    logic                         finish;

    assign cur    = nfcs_pkg::step_result(job_reg.seq, step_reg, job_reg.off, job_reg.dat);
    assign emit   = job_reg.valid && (!out_valid_reg || out_ready);
    assign finish = emit && cur.last;
    // a new job may enter while the last beat of the current one moves out
    assign ready  = !job_reg.valid || finish;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_reg       <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end else begin
            if (accept) begin
                job_reg  <= job_in;
                step_reg <= '0;
            end else if (finish) begin
                job_reg.valid <= 1'b0;
                step_reg      <= '0;
            end else if (emit) begin
                step_reg <= step_reg + 1'b1;
            end
            if (emit) begin
                out_valid_reg <= 1'b1;
                out_reg       <= cur;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

endmodule

`default_nettype wire

// File: rtl/nor_flash_command_sequencer_top.sv
// top level of the nor flash command sequencer
`default_nettype none

// Host-side sequencer for a 16-bit NOR flash with the AMD/JEDEC command set.
// Each request beat (program, sector erase, id enter, cfi enter, reset, read,
// or a read return from the flash) is turned into the result beats the flash
// bus needs: unlock and command writes, bus reads, a done report, read data
// passed back, or a reject. The word offset is the byte address, masked to
// ADDR_BITS, shifted right by one. After a program or erase two status reads
// go out and the block polls: each returned status word is compared on bit 6
// with the previous one; while it toggles another read is issued, and once
// two agree a done beat carries the final status word. While polling, any
// request other than a read return is rejected, and status words are not
// passed back as read data. The first status return gives no result beat.
// Rate: a request is decoded into a job register in the cycle it is taken,
// and the job's results leave through an output register one beat a cycle
// while m_tready does not hold the output back; a program gives 6 beats,
// an erase 8, id enter 3 and all others 1, and a status return may give none.
// The next request is taken in the cycle the last beat of the current job
// moves into the output register; a request passes the job register and then
// the output register before its first result shows on the result channel.
// m_tlast marks the last beat caused by a request.
module nor_flash_command_sequencer_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // request channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,   // byte_address[23:0], write_data[39:24], read_data[55:40]
    input  wire logic [2:0]  s_tuser,   // action[2:0]
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // word_offset[22:0], bus_data[38:23], zero pad[39]
    output logic [2:0]       m_tuser,   // kind[2:0]
    output logic             m_tlast    // last beat caused by this request
);

    logic              accept;
    nfcs_pkg::job_t    job;
    nfcs_pkg::result_t res;

    assign accept = s_tvalid && s_tready;

    // decode and poll state, updated on every accepted request
    nfcs_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .action       (s_tuser),
        .byte_address (s_tdata[23:0]),
        .write_data   (s_tdata[39:24]),
        .read_data    (s_tdata[55:40]),
        .job          (job)
    );

    // walks the job's bus cycles out through the output register
    nfcs_emit u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .job_in     (job),
        .ready      (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (res)
    );

    assign m_tdata = {1'b0, res.bus_data, res.word_offset};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

endmodule

`default_nettype wire

// File: tb/sv/nor_flash_command_sequencer_top_tb.sv
// self-checking testbench of the nor flash command sequencer top level
`timescale 1ns / 1ps

module nor_flash_command_sequencer_top_tb;
    import nfcs_pkg::*;

    // the one request code the block does not define
    localparam logic [ACTION_W-1:0] ACT_UNDEF = 3'd7;
    localparam int TOTAL_ITEMS = 270;
    localparam int SETTLE_CYCLES = 20;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;   // byte_address[23:0], write_data[39:24], read_data[55:40]
    logic [2:0]  s_tuser;   // action[2:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // word_offset[22:0], bus_data[38:23], zero pad[39]
    logic [2:0]  m_tuser;   // kind[2:0]
    logic        m_tlast;

    // one row of the directed table; a typed beat replaces the predicted one
    typedef struct {
        logic [ACTION_W-1:0]    act;
        logic [BYTE_ADDR_W-1:0] addr;
        logic [DATA_W-1:0]      wdata;
        logic [DATA_W-1:0]      rdata;
        bit                     typed;
        result_t                beat;
    } request_row_t;

    // predictor state: poll phase, last toggle bit seen, offset under poll
    logic [1:0]       polling_phase;
    logic             last_toggle;
    logic [OFF_W-1:0] polled_offset;

    result_t      new_beats[$];      // beats caused by the request just taken
    result_t      pending_beats[$];  // beats still owed by the block, oldest first
    result_t      want_beat;
    request_row_t directed_rows[$];
    int           error_count;
    int           item_count;
    bit           no_idle;

    nor_flash_command_sequencer_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // 2 ns clock
    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // ------------------------------------------------------------------
    // predictor of the bus cycles a request causes
    // ------------------------------------------------------------------

    function automatic void add_beat(input logic [KIND_W-1:0] kind,
                                     input logic [OFF_W-1:0] off,
                                     input logic [DATA_W-1:0] dat);
        result_t r;
        r.kind        = kind;
        r.word_offset = off;
        r.bus_data    = dat;
        r.last        = 1'b0;
        new_beats.push_back(r);
    endfunction

    function automatic void add_unlock();
        add_beat(KIND_WRITE, UNLOCK1_ADDR, UNLOCK1_DATA);
        add_beat(KIND_WRITE, UNLOCK2_ADDR, UNLOCK2_DATA);
    endfunction

    function automatic void predict_bus_cycles(input logic [ACTION_W-1:0] act,
                                               input logic [BYTE_ADDR_W-1:0] addr,
                                               input logic [DATA_W-1:0] wdata,
                                               input logic [DATA_W-1:0] rdata);
        logic [OFF_W-1:0] off;
        logic             tbit;
        result_t          r;
        off  = OFF_W'((addr & ADDR_MASK) >> 1);
        tbit = rdata[TOGGLE_BIT];
        new_beats.delete();
        if (polling_phase != PHASE_IDLE) begin
            // only status returns get through while polling
            if (act != ACT_READ_RET) begin
                add_beat(KIND_REJECT, '0, '0);
            end else if (polling_phase == PHASE_FIRST) begin
                last_toggle   = tbit;
                polling_phase = PHASE_LATER;
            end else if (tbit == last_toggle) begin
                add_beat(KIND_DONE, polled_offset, rdata);
                polling_phase = PHASE_IDLE;
            end else begin
                last_toggle = tbit;
                add_beat(KIND_READ, polled_offset, '0);
            end
        end else begin
            case (act)
                ACT_PROGRAM: begin
                    add_unlock();
                    add_beat(KIND_WRITE, UNLOCK1_ADDR, CMD_PROGRAM);
                    add_beat(KIND_WRITE, off, wdata);
                    add_beat(KIND_READ, off, '0);
                    add_beat(KIND_READ, off, '0);
                    polled_offset = off;
                    polling_phase = PHASE_FIRST;
                end
                ACT_ERASE: begin
                    add_unlock();
                    add_beat(KIND_WRITE, UNLOCK1_ADDR, CMD_ERASE);
                    add_unlock();
                    add_beat(KIND_WRITE, off, CMD_SECTOR);
                    add_beat(KIND_READ, off, '0);
                    add_beat(KIND_READ, off, '0);
                    polled_offset = off;
                    polling_phase = PHASE_FIRST;
                end
                ACT_ID: begin
                    add_unlock();
                    add_beat(KIND_WRITE, UNLOCK1_ADDR, CMD_ID);
                end
                ACT_CFI:      add_beat(KIND_WRITE, CFI_ADDR, CMD_CFI);
                ACT_RESET:    add_beat(KIND_WRITE, '0, CMD_RESET);
                ACT_READ:     add_beat(KIND_READ, off, '0);
                ACT_READ_RET: add_beat(KIND_RDATA, '0, rdata);
                default:      add_beat(KIND_REJECT, '0, '0);
            endcase
        end
        if (new_beats.size() > 0) begin
            r      = new_beats.pop_back();
            r.last = 1'b1;
            new_beats.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------

    // idle gap: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // drive one request beat, wait for its handshake, then book its results
    task automatic send_request(input logic [ACTION_W-1:0] act,
                                input logic [BYTE_ADDR_W-1:0] addr,
                                input logic [DATA_W-1:0] wdata,
                                input logic [DATA_W-1:0] rdata,
                                input bit typed,
                                input result_t typed_beat);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        // valid only drops when a gap follows, so it never toggles within one step
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {rdata, wdata, addr};
        do @(posedge aclk); while (!s_tready);
        predict_bus_cycles(act, addr, wdata, rdata);
        if (typed) begin
            new_beats.delete();
            new_beats.push_back(typed_beat);
        end
        foreach (new_beats[i]) pending_beats.push_back(new_beats[i]);
        item_count++;
    endtask

    task automatic send_random(input logic [ACTION_W-1:0] act,
                               input logic [DATA_W-1:0] rdata);
        send_request(act, BYTE_ADDR_W'($urandom), DATA_W'($urandom), rdata, 1'b0, '0);
    endtask

    // hold the request side until every owed beat has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_beats.size() != 0) @(posedge aclk);
    endtask

    // stray request in the middle of a poll; a status return is swapped for the undefined code, so it is rejected
    task automatic maybe_interrupt();
        logic [ACTION_W-1:0] act;
        if ($urandom_range(0, 5) == 0) begin
            act = ACTION_W'($urandom_range(0, 6));
            if (act == ACT_READ_RET) act = ACT_UNDEF;
            send_random(act, DATA_W'($urandom));
        end
    endtask

    // program or erase, then status words that toggle a few times and settle;
    // now and then the sequence is cut short and the poll is left open
    task automatic run_poll_sequence();
        logic [DATA_W-1:0] status;
        logic              tbit;
        int                toggles;
        send_random($urandom_range(0, 1) ? ACT_ERASE : ACT_PROGRAM, DATA_W'($urandom));
        maybe_interrupt();
        status = DATA_W'($urandom);
        tbit   = status[TOGGLE_BIT];
        send_random(ACT_READ_RET, status);
        toggles = $urandom_range(0, 4);
        repeat (toggles) begin
            maybe_interrupt();
            status             = DATA_W'($urandom);
            status[TOGGLE_BIT] = ~tbit;
            tbit               = ~tbit;
            send_random(ACT_READ_RET, status);
        end
        if ($urandom_range(0, 7) == 0) return;
        maybe_interrupt();
        status             = DATA_W'($urandom);
        status[TOGGLE_BIT] = tbit;
        send_random(ACT_READ_RET, status);
    endtask

    function automatic request_row_t table_row(input logic [ACTION_W-1:0] act,
                                               input logic [BYTE_ADDR_W-1:0] addr,
                                               input logic [DATA_W-1:0] wdata,
                                               input logic [DATA_W-1:0] rdata,
                                               input bit typed,
                                               input logic [KIND_W-1:0] kind,
                                               input logic [OFF_W-1:0] off,
                                               input logic [DATA_W-1:0] dat);
        request_row_t row;
        row.act              = act;
        row.addr             = addr;
        row.wdata            = wdata;
        row.rdata            = rdata;
        row.typed            = typed;
        row.beat.kind        = kind;
        row.beat.word_offset = off;
        row.beat.bus_data    = dat;
        row.beat.last        = 1'b1;
        return row;
    endfunction

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    initial begin
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        polling_phase = PHASE_IDLE;
        last_toggle   = 1'b0;
        polled_offset = '0;
        error_count   = 0;
        item_count    = 0;
        no_idle       = 1'b0;

        // single-beat answers, readable straight off the command set
        directed_rows.push_back(table_row(ACT_RESET, 24'h000000, 16'h0000, 16'h0000,
                                          1'b1, KIND_WRITE, '0, CMD_RESET));
        directed_rows.push_back(table_row(ACT_CFI, 24'hFFFFFF, 16'hFFFF, 16'hFFFF,
                                          1'b1, KIND_WRITE, CFI_ADDR, CMD_CFI));
        directed_rows.push_back(table_row(ACT_UNDEF, 24'hFFFFFF, 16'hFFFF, 16'hFFFF,
                                          1'b1, KIND_REJECT, '0, '0));
        directed_rows.push_back(table_row(ACT_READ, 24'hFFFFFF, 16'h0000, 16'h0000,
                                          1'b1, KIND_READ, 23'h7FFFFF, '0));
        directed_rows.push_back(table_row(ACT_READ, 24'h000001, 16'hFFFF, 16'hFFFF,
                                          1'b1, KIND_READ, '0, '0));
        // read return while idle is handed back as read data
        directed_rows.push_back(table_row(ACT_READ_RET, 24'hFFFFFF, 16'h0000, 16'hFFFF,
                                          1'b1, KIND_RDATA, '0, 16'hFFFF));
        directed_rows.push_back(table_row(ACT_READ_RET, 24'h000000, 16'hFFFF, 16'h0000,
                                          1'b1, KIND_RDATA, '0, '0));
        directed_rows.push_back(table_row(ACT_ID, 24'h123456, 16'hA5A5, 16'h5A5A,
                                          1'b0, '0, '0, '0));
        // program at the top word, then requests refused while polling
        directed_rows.push_back(table_row(ACT_PROGRAM, 24'hFFFFFE, 16'hFFFF, 16'h0000,
                                          1'b0, '0, '0, '0));
        directed_rows.push_back(table_row(ACT_READ, 24'h000100, 16'h0000, 16'h0000,
                                          1'b1, KIND_REJECT, '0, '0));
        directed_rows.push_back(table_row(ACT_UNDEF, 24'h000000, 16'h0000, 16'h0000,
                                          1'b1, KIND_REJECT, '0, '0));
        directed_rows.push_back(table_row(ACT_PROGRAM, 24'h000000, 16'h0000, 16'h0000,
                                          1'b1, KIND_REJECT, '0, '0));
        // first status stores bit 6, a toggle asks again, a match reports done
        directed_rows.push_back(table_row(ACT_READ_RET, 24'h000000, 16'h0000, 16'h0040,
                                          1'b0, '0, '0, '0));
        directed_rows.push_back(table_row(ACT_READ_RET, 24'h000000, 16'h0000, 16'h0000,
                                          1'b0, '0, '0, '0));
        directed_rows.push_back(table_row(ACT_READ_RET, 24'hFFFFFF, 16'hFFFF, 16'hFFBF,
                                          1'b0, '0, '0, '0));
        // erase at zero, settled on the first comparison
        directed_rows.push_back(table_row(ACT_ERASE, 24'h000000, 16'h1234, 16'hFFFF,
                                          1'b0, '0, '0, '0));
        directed_rows.push_back(table_row(ACT_READ_RET, 24'h000000, 16'h0000, 16'hFFFF,
                                          1'b0, '0, '0, '0));
        directed_rows.push_back(table_row(ACT_READ_RET, 24'h000000, 16'h0000, 16'h0040,
                                          1'b0, '0, '0, '0));
        // erase at the top, two toggles before it settles
        directed_rows.push_back(table_row(ACT_ERASE, 24'hFFFFFF, 16'hFFFF, 16'h0000,
                                          1'b0, '0, '0, '0));
        directed_rows.push_back(table_row(ACT_READ_RET, 24'h000000, 16'h0000, 16'h0000,
                                          1'b0, '0, '0, '0));
        directed_rows.push_back(table_row(ACT_READ_RET, 24'h000000, 16'h0000, 16'h0040,
                                          1'b0, '0, '0, '0));
        directed_rows.push_back(table_row(ACT_READ_RET, 24'h000000, 16'h0000, 16'h0000,
                                          1'b0, '0, '0, '0));
        directed_rows.push_back(table_row(ACT_READ_RET, 24'h000000, 16'h0000, 16'h0000,
                                          1'b0, '0, '0, '0));

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            send_request(directed_rows[i].act, directed_rows[i].addr,
                         directed_rows[i].wdata, directed_rows[i].rdata,
                         directed_rows[i].typed, directed_rows[i].beat);
        end
        drain_results();

        // random part: mostly poll sequences, the rest stray single requests
        while (item_count < TOTAL_ITEMS) begin
            no_idle = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) < 6) begin
                run_poll_sequence();
            end else begin
                send_random(ACTION_W'($urandom_range(2, 7)), DATA_W'($urandom));
            end
            if ($urandom_range(0, 29) == 0) drain_results();
        end

        // wait for the owed beats, then a little longer for any stray one
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("PASS nor_flash_command_sequencer_top");
        end else begin
            $display("FAIL nor_flash_command_sequencer_top");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // result side: random back-pressure
    // ------------------------------------------------------------------

    initial begin
        int burst;
        int stall;
        m_tready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            // ready stretches, sometimes long, broken by stalls of random length
            burst = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                : $urandom_range(1, 12);
            m_tready <= 1'b1;
            repeat (burst) @(posedge aclk);
            stall = pick_gap();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    // compare every accepted result beat with the oldest one owed
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_beats.size() == 0) begin
                $error("result beat with none owed: kind %0d word_offset %h bus_data %h",
                       m_tuser, m_tdata[22:0], m_tdata[38:23]);
                error_count++;
            end else begin
                want_beat = pending_beats.pop_front();
                if (m_tuser !== want_beat.kind) begin
                    $error("kind mismatch: expected %0d, got %0d", want_beat.kind, m_tuser);
                    error_count++;
                end
                if (m_tdata[22:0] !== want_beat.word_offset) begin
                    $error("word_offset mismatch: expected %h, got %h",
                           want_beat.word_offset, m_tdata[22:0]);
                    error_count++;
                end
                if (m_tdata[38:23] !== want_beat.bus_data) begin
                    $error("bus_data mismatch: expected %h, got %h",
                           want_beat.bus_data, m_tdata[38:23]);
                    error_count++;
                end
                if (m_tlast !== want_beat.last) begin
                    $error("last mismatch: expected %b, got %b", want_beat.last, m_tlast);
                    error_count++;
                end
                if (m_tdata[39] !== 1'b0) begin
                    $error("pad mismatch: expected 0, got %b", m_tdata[39]);
                    error_count++;
                end
            end
        end
    end

    // watchdog, several times the slowest legal run
    initial begin
        #1000000;
        $display("FAIL nor_flash_command_sequencer_top");
        $finish;
    end

endmodule
